// File: hw/rtl/bms_reply_frame_checker_unit_defines.svh
// assertion macros for the reply frame checker
`ifndef BMS_REPLY_FRAME_CHECKER_UNIT_DEFINES_SVH
`define BMS_REPLY_FRAME_CHECKER_UNIT_DEFINES_SVH

// same-cycle implication
`define BMS_RFC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BMS_RFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/bms_rfc_pkg.sv
// shared types and constants of the reply frame checker
`default_nettype none

package bms_rfc_pkg;

   localparam int BUFFER_DEPTH_DEFAULT = 64;

   localparam logic [7:0] START_MARK     = 8'hDD;
   localparam logic [7:0] END_MARK       = 8'h77;
   localparam logic [7:0] MIN_STRUCT_LEN = 8'd7;

   localparam logic [6:0] MIN_FRAME_LENGTH_RESET = 7'd7;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_IDX_MIN_FRAME_LENGTH = 1'b0;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 32;

   localparam logic [2:0] VERDICT_OK        = 3'd0;
   localparam logic [2:0] VERDICT_SHORT     = 3'd1;
   localparam logic [2:0] VERDICT_BAD_MARK  = 3'd2;
   localparam logic [2:0] VERDICT_STATUS    = 3'd3;
   localparam logic [2:0] VERDICT_LENGTH    = 3'd4;
   localparam logic [2:0] VERDICT_CHECKSUM  = 3'd5;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_end;
   } req_item_type;

   typedef struct packed {
      logic [7:0] payload_length;
      logic [7:0] command_code;
      logic [6:0] frame_length;
      logic [2:0] verdict;
   } rsp_item_type;

endpackage

`default_nettype wire

// File: hw/rtl/bms_rfc_input_reg.sv
// input register holding one request byte
`default_nettype none

module bms_rfc_input_reg (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  bms_rfc_pkg::req_item_type   req_item,
   output logic                        item_valid,
   output bms_rfc_pkg::req_item_type   item,
   input  wire                         item_consume
);

   logic                      vld_ff;
   logic                      vld_in;
   bms_rfc_pkg::req_item_type item_ff;

   assign req_ready  = !vld_ff || item_consume;
   assign item_valid = vld_ff;
   assign item       = item_ff;

   always_comb begin
      if (req_valid && req_ready) begin
         vld_in = 1'b1;
      end else if (item_consume) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/bms_rfc_frame_track.sv
// per-frame state and verdict logic
`default_nettype none

module bms_rfc_frame_track #(
   parameter int BUFFER_DEPTH = bms_rfc_pkg::BUFFER_DEPTH_DEFAULT
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         item_valid,
   input  bms_rfc_pkg::req_item_type   item,
   output logic                        item_consume,
   input  wire                         result_free,
   input  wire  [6:0]                  min_frame_length,
   output logic                        result_load,
   output bms_rfc_pkg::rsp_item_type   result
);

   localparam int CntW = $clog2(BUFFER_DEPTH + 1);

   logic [CntW-1:0] count_ff, count_in, count_take;
   logic [15:0]     lag_sum_ff, lag_sum_in, lag_sum_take;
   logic [7:0]      r0_ff, r0_in, r0_take;
   logic [7:0]      r1_ff, r1_in, r1_take;
   logic [7:0]      r2_ff, r2_in, r2_take;
   logic            start_ok_ff, start_ok_in, start_ok_take;
   logic            status_ok_ff, status_ok_in, status_ok_take;
   logic [7:0]      command_ff, command_in, command_take;
   logic [7:0]      length_ff, length_in, length_take;

   logic              take;
   logic [CntW+7:0]   cnt_wide;
   logic [7:0]        len8;
   logic [15:0]       check_sum;

   assign item_consume = item_valid && (!item.frame_end || result_free);
   assign result_load  = item_consume && item.frame_end;

   // update as if the byte is kept
   always_comb begin
      take           = count_ff < CntW'(BUFFER_DEPTH);
      count_take     = take ? count_ff + CntW'(1) : count_ff;
      start_ok_take  = (take && count_ff == CntW'(0)) ?
                       (item.rx_byte == bms_rfc_pkg::START_MARK) : start_ok_ff;
      command_take   = (take && count_ff == CntW'(1)) ? item.rx_byte : command_ff;
      status_ok_take = (take && count_ff == CntW'(2)) ?
                       (item.rx_byte == 8'd0) : status_ok_ff;
      length_take    = (take && count_ff == CntW'(3)) ? item.rx_byte : length_ff;
      // byte leaving the window joins the checksum body from offset 2 on
      lag_sum_take   = (take && count_ff >= CntW'(5)) ?
                       lag_sum_ff + {8'd0, r2_ff} : lag_sum_ff;
      r0_take        = take ? item.rx_byte : r0_ff;
      r1_take        = take ? r0_ff : r1_ff;
      r2_take        = take ? r1_ff : r2_ff;
   end

   always_comb begin
      cnt_wide  = {8'd0, count_take};
      len8      = cnt_wide[7:0];
      check_sum = lag_sum_take + {r2_take, r1_take};

      if (len8 < {1'b0, min_frame_length} || len8 < bms_rfc_pkg::MIN_STRUCT_LEN) begin
         result.verdict = bms_rfc_pkg::VERDICT_SHORT;
      end else if (!start_ok_take || r0_take != bms_rfc_pkg::END_MARK) begin
         result.verdict = bms_rfc_pkg::VERDICT_BAD_MARK;
      end else if (!status_ok_take) begin
         result.verdict = bms_rfc_pkg::VERDICT_STATUS;
      end else if (length_take != len8 - bms_rfc_pkg::MIN_STRUCT_LEN) begin
         result.verdict = bms_rfc_pkg::VERDICT_LENGTH;
      end else if (check_sum != 16'd0) begin
         result.verdict = bms_rfc_pkg::VERDICT_CHECKSUM;
      end else begin
         result.verdict = bms_rfc_pkg::VERDICT_OK;
      end
      result.frame_length   = cnt_wide[6:0];
      result.command_code   = command_take;
      result.payload_length = length_take;
   end

   // frame close returns to the idle frame state
   always_comb begin
      if (item.frame_end) begin
         count_in     = '0;
         lag_sum_in   = '0;
         r0_in        = '0;
         r1_in        = '0;
         r2_in        = '0;
         start_ok_in  = 1'b0;
         status_ok_in = 1'b0;
         command_in   = '0;
         length_in    = '0;
      end else begin
         count_in     = count_take;
         lag_sum_in   = lag_sum_take;
         r0_in        = r0_take;
         r1_in        = r1_take;
         r2_in        = r2_take;
         start_ok_in  = start_ok_take;
         status_ok_in = status_ok_take;
         command_in   = command_take;
         length_in    = length_take;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         lag_sum_ff   <= '0;
         r0_ff        <= '0;
         r1_ff        <= '0;
         r2_ff        <= '0;
         start_ok_ff  <= 1'b0;
         status_ok_ff <= 1'b0;
         command_ff   <= '0;
         length_ff    <= '0;
      end else if (item_consume) begin
         count_ff     <= count_in;
         lag_sum_ff   <= lag_sum_in;
         r0_ff        <= r0_in;
         r1_ff        <= r1_in;
         r2_ff        <= r2_in;
         start_ok_ff  <= start_ok_in;
         status_ok_ff <= status_ok_in;
         command_ff   <= command_in;
         length_ff    <= length_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/bms_rfc_result_reg.sv
// output register for verdicts
`default_nettype none

module bms_rfc_result_reg (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         result_load,
   input  bms_rfc_pkg::rsp_item_type   result,
   output logic                        result_free,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output bms_rfc_pkg::rsp_item_type   rsp_item
);

   logic                      vld_ff;
   logic                      vld_in;
   bms_rfc_pkg::rsp_item_type data_ff;

   assign result_free = !vld_ff || rsp_ready;
   assign rsp_valid   = vld_ff;
   assign rsp_item    = data_ff;

   always_comb begin
      if (result_load) begin
         vld_in = 1'b1;
      end else if (rsp_ready) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (result_load) begin
         data_ff <= result;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/bms_reply_frame_checker_unit.sv
// the closing byte is registered in the input register, and its verdict is registered in the result register
// throughput: one request byte per cycle while no closing byte waits on an untaken verdict; state updates per byte
// a closing byte waits in the input register only while an earlier verdict is not taken
// reset: synchronous, clears the frame state and both stage valids
// reset: min_frame_length returns to 7
`default_nettype none
`include "bms_reply_frame_checker_unit_defines.svh"

module bms_reply_frame_checker_unit #(
   parameter int BUFFER_DEPTH = bms_rfc_pkg::BUFFER_DEPTH_DEFAULT
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_tvalid,
   output logic                                   req_tready,
   input  wire  [bms_rfc_pkg::REQ_TDATA_W-1:0]    req_tdata,  // [7:0] rx_byte
   input  wire                                    req_tlast,
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   // [2:0] verdict, [9:3] frame_length, [17:10] command_code, [25:18] payload_length
   output logic [bms_rfc_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  wire                                    csr_psel,
   input  wire                                    csr_penable,
   input  wire                                    csr_pwrite,
   input  wire  [bms_rfc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire  [bms_rfc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [bms_rfc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                   csr_pready
);

   bms_rfc_pkg::req_item_type req_item;
   bms_rfc_pkg::req_item_type item;
   bms_rfc_pkg::rsp_item_type result;
   bms_rfc_pkg::rsp_item_type rsp_item;

   logic       item_valid;
   logic       item_consume;
   logic       result_free;
   logic       result_load;
   logic       csr_wr_en;
   logic [6:0] min_len_ff;
   logic [6:0] min_len_in;

   assign req_item.rx_byte   = req_tdata[7:0];
   assign req_item.frame_end = req_tlast;

   assign rsp_tdata = {{(bms_rfc_pkg::RSP_TDATA_W - $bits(rsp_item)){1'b0}}, rsp_item};

   // config register
   assign csr_pready = 1'b1;
   assign csr_wr_en  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == bms_rfc_pkg::REG_IDX_MIN_FRAME_LENGTH);
   assign min_len_in = csr_wr_en ? csr_pwdata[6:0] : min_len_ff;
   assign csr_prdata = (csr_paddr[2] == bms_rfc_pkg::REG_IDX_MIN_FRAME_LENGTH) ?
                       {{(bms_rfc_pkg::CSR_DATA_W - 7){1'b0}}, min_len_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= bms_rfc_pkg::MIN_FRAME_LENGTH_RESET;
      end else begin
         min_len_ff <= min_len_in;
      end
   end

   bms_rfc_input_reg u_input_reg (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_item     (req_item),
      .item_valid   (item_valid),
      .item         (item),
      .item_consume (item_consume)
   );

   bms_rfc_frame_track #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_frame_track (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (item_valid),
      .item             (item),
      .item_consume     (item_consume),
      .result_free      (result_free),
      .min_frame_length (min_len_ff),
      .result_load      (result_load),
      .result           (result)
   );

   bms_rfc_result_reg u_result_reg (
      .clock       (clock),
      .reset       (reset),
      .result_load (result_load),
      .result      (result),
      .result_free (result_free),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_item    (rsp_item)
   );

   `BMS_RFC_ASSERT_NOW(a_stall_only_on_blocked_verdict, clock, reset, !req_tready, rsp_tvalid && !rsp_tready && item_valid, "request stalled without a blocked verdict")
   `BMS_RFC_ASSERT_NEXT(a_csr_write_lands, clock, reset, csr_wr_en, min_len_ff == $past(csr_pwdata[6:0]), "min_frame_length write lost")
   `BMS_RFC_ASSERT_NEXT(a_close_fills_result, clock, reset, result_load, rsp_tvalid, "closed frame gave no verdict")

endmodule

`default_nettype wire
